/* rtl/core/ata_pio_sector_sequencer_unit_defines.svh */
// Assertion macros used by the ATA PIO sector sequencer top level.
`ifndef ATA_PIO_SECTOR_SEQUENCER_UNIT_DEFINES_SVH
`define ATA_PIO_SECTOR_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define APS_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define APS_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/aps_pkg.sv */
// Types, codes and the task-file beat function of the ATA PIO sector sequencer.
`default_nettype none

package aps_pkg;

   // Default sector size in 16-bit words and reset value of the poll limit.
   localparam int          WORDS_PER_SECTOR_DEF = 256;
   localparam logic [23:0] POLL_LIMIT_RST       = 24'd1000000;

   // Input beat kinds.
   localparam logic [1:0] KIND_START  = 2'd0;
   localparam logic [1:0] KIND_STATUS = 2'd1;
   localparam logic [1:0] KIND_DATA   = 2'd2;

   // Result beat kinds.
   localparam logic [1:0] OK_REG_WRITE = 2'd0;
   localparam logic [1:0] OK_READ_WORD = 2'd1;
   localparam logic [1:0] OK_DONE      = 2'd2;

   // Completion status codes.
   localparam logic [1:0] ST_SUCCESS = 2'd0;
   localparam logic [1:0] ST_REFUSED = 2'd1;
   localparam logic [1:0] ST_FAILED  = 2'd2;

   // Task-file register offsets.
   localparam logic [2:0] TF_DATA    = 3'd0;
   localparam logic [2:0] TF_COUNT   = 3'd2;
   localparam logic [2:0] TF_LBA_LO  = 3'd3;
   localparam logic [2:0] TF_LBA_MID = 3'd4;
   localparam logic [2:0] TF_LBA_HI  = 3'd5;
   localparam logic [2:0] TF_DEVICE  = 3'd6;
   localparam logic [2:0] TF_COMMAND = 3'd7;

   // Command and device register codes.
   localparam logic [7:0] CMD_READ      = 8'h20;
   localparam logic [7:0] CMD_WRITE     = 8'h30;
   localparam logic [7:0] CMD_READ_EXT  = 8'h24;
   localparam logic [7:0] CMD_WRITE_EXT = 8'h34;
   localparam logic [7:0] CMD_FLUSH     = 8'hE7;
   localparam logic [7:0] DEV_LBA28     = 8'hE0;
   localparam logic [7:0] DEV_LBA48     = 8'h40;
   localparam logic [7:0] DEV_SLAVE     = 8'h10;

   // Status register bits.
   localparam int SR_BSY_BIT = 7;
   localparam int SR_DRQ_BIT = 3;
   localparam int SR_ERR_BIT = 0;

   // Configuration register indexes.
   localparam logic [1:0] CSR_DRIVE_PRESENT = 2'd0;
   localparam logic [1:0] CSR_DRIVE_SLAVE   = 2'd1;
   localparam logic [1:0] CSR_LBA48         = 2'd2;
   localparam logic [1:0] CSR_POLL_LIMIT    = 2'd3;

   // Task-file sequence lengths in beats.
   localparam logic [3:0] TF_BEATS_LBA28 = 4'd6;
   localparam logic [3:0] TF_BEATS_LBA48 = 4'd10;

   // Transfer phase, one-hot.
   typedef enum logic [4:0] {
      PH_IDLE  = 5'b00001,
      PH_BSY   = 5'b00010,
      PH_DRQ   = 5'b00100,
      PH_DATA  = 5'b01000,
      PH_FLUSH = 5'b10000
   } phase_type;

   // One result beat.
   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  reg_addr;
      logic [15:0] value;
      logic [1:0]  status;
   } result_type;

   // Results caused by one input beat: up to two plain beats or a task-file run.
   typedef struct packed {
      logic        task_file;
      logic [3:0]  count;
      result_type  first;
      result_type  second;
      logic [47:0] lba;
      logic        slave;
      logic        ext;
      logic        write;
   } burst_type;

   function automatic result_type make_result(logic [1:0] kind, logic [2:0] addr,
                                              logic [15:0] value, logic [1:0] status);
      result_type r;
      r.kind     = kind;
      r.reg_addr = addr;
      r.value    = value;
      r.status   = status;
      return r;
   endfunction

   // Register write number beat of the task-file run described by b.
   function automatic result_type tf_beat(burst_type b, logic [3:0] beat);
      logic [3:0]  j;
      logic [7:0]  sel;
      logic [7:0]  cmd;
      logic [7:0]  v;
      logic [2:0]  a;
      sel = b.slave ? DEV_SLAVE : 8'h00;
      if (b.ext) begin
         cmd = b.write ? CMD_WRITE_EXT : CMD_READ_EXT;
         j   = beat - 4'd5;
      end else begin
         cmd = b.write ? CMD_WRITE : CMD_READ;
         j   = beat - 4'd1;
      end
      v = 8'h00;
      a = TF_COMMAND;
      if (b.ext && beat < 4'd5) begin
         // High-order half of the 48-bit task file.
         case (beat)
            4'd0: begin a = TF_DEVICE;  v = DEV_LBA48 | sel; end
            4'd1: begin a = TF_COUNT;   v = 8'h00; end
            4'd2: begin a = TF_LBA_LO;  v = b.lba[31:24]; end
            4'd3: begin a = TF_LBA_MID; v = b.lba[39:32]; end
            default: begin a = TF_LBA_HI; v = b.lba[47:40]; end
         endcase
      end else if (!b.ext && beat == 4'd0) begin
         a = TF_DEVICE;
         v = DEV_LBA28 | sel | {4'h0, b.lba[27:24]};
      end else begin
         // Low-order registers and the command, common to both modes.
         case (j)
            4'd0: begin a = TF_COUNT;   v = 8'h01; end
            4'd1: begin a = TF_LBA_LO;  v = b.lba[7:0]; end
            4'd2: begin a = TF_LBA_MID; v = b.lba[15:8]; end
            4'd3: begin a = TF_LBA_HI;  v = b.lba[23:16]; end
            default: begin a = TF_COMMAND; v = cmd; end
         endcase
      end
      return make_result(OK_REG_WRITE, a, {8'h00, v}, ST_SUCCESS);
   endfunction

endpackage

`default_nettype wire

/* rtl/core/ata_pio_sector_sequencer_unit.sv */
// Top level of the host-side ATA PIO sector sequencer (LBA28 and LBA48).
//
//   channel  direction  beat contents
//   req_*    in         tuser kind; tdata op_write, lba, sector_count, status_byte, data_word
//   rsp_*    out        tuser out_kind; tdata reg_addr, value, status; tlast last
//   csr_*    in         index and data of one configuration register write
//
// Every input beat is handled in the cycle it is accepted; its results sit in
// the result register and leave one per cycle while rsp_tready is high; a beat
// causes 0, 1, 2, 6 or 10 results. The next input beat can be
// taken in the cycle the final result of the previous one is taken.
// Reset is synchronous and clears the phase, counters and configuration.
// A stalled rsp side holds its beat, and req stays stalled until the final beat is taken.

`default_nettype none
`include "ata_pio_sector_sequencer_unit_defines.svh"

module ata_pio_sector_sequencer_unit #(
   parameter int WORDS_PER_SECTOR = aps_pkg::WORDS_PER_SECTOR_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [111:0] req_tdata,   // op_write[0], lba[48:1], sector_count[80:49],
                                          // status_byte[88:81], data_word[104:89]
   input  wire logic [1:0]   req_tuser,   // kind[1:0]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [23:0]       rsp_tdata,   // reg_addr[2:0], value[18:3], status[20:19]
   output logic [1:0]        rsp_tuser,   // out_kind[1:0]
   output logic              rsp_tlast,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [23:0]  csr_wdata
);

   localparam int WI_W = $clog2(WORDS_PER_SECTOR);

   // Configuration registers.
   logic        drive_present_ff;
   logic        drive_slave_ff;
   logic        lba48_ff;
   logic [23:0] poll_limit_ff;

   // Transfer state.
   aps_pkg::phase_type phase_ff, phase_in;
   logic               is_write_ff, is_write_in;
   logic [47:0]        current_lba_ff, current_lba_in;
   logic [31:0]        sectors_left_ff, sectors_left_in;
   logic [WI_W-1:0]    word_index_ff, word_index_in;
   logic [23:0]        poll_count_ff, poll_count_in;

   // Input fields.
   logic [1:0]  in_kind;
   logic        in_op_write;
   logic [47:0] in_lba;
   logic [31:0] in_count;
   logic [7:0]  in_status;
   logic [15:0] in_word;

   logic               req_accept;
   logic               burst_load;
   aps_pkg::burst_type burst;
   logic [24:0]        poll_next;
   logic               poll_expired;
   logic [31:0]        sectors_dec;
   logic               last_word;
   logic               st_bsy, st_drq, st_err;
   aps_pkg::result_type done_ok;

   assign in_kind     = req_tuser;
   assign in_op_write = req_tdata[0];
   assign in_lba      = req_tdata[48:1];
   assign in_count    = req_tdata[80:49];
   assign in_status   = req_tdata[88:81];
   assign in_word     = req_tdata[104:89];

   assign req_accept = req_tvalid && req_tready;
   assign burst_load = req_accept && (burst.count != 4'd0);

   assign poll_next    = {1'b0, poll_count_ff} + 25'd1;
   assign poll_expired = (poll_next >= {1'b0, poll_limit_ff});
   assign sectors_dec  = sectors_left_ff - 32'd1;
   assign last_word    = (word_index_ff == WI_W'(WORDS_PER_SECTOR - 1));
   assign st_bsy       = in_status[aps_pkg::SR_BSY_BIT];
   assign st_drq       = in_status[aps_pkg::SR_DRQ_BIT];
   assign st_err       = in_status[aps_pkg::SR_ERR_BIT];
   assign done_ok      = aps_pkg::make_result(aps_pkg::OK_DONE, aps_pkg::TF_DATA, 16'h0000,
                                              aps_pkg::ST_SUCCESS);

   // Next state and the results of the beat on the input.
   always_comb begin
      phase_in        = phase_ff;
      is_write_in     = is_write_ff;
      current_lba_in  = current_lba_ff;
      sectors_left_in = sectors_left_ff;
      word_index_in   = word_index_ff;
      poll_count_in   = poll_count_ff;

      burst           = '0;
      burst.lba       = current_lba_ff;
      burst.slave     = drive_slave_ff;
      burst.ext       = lba48_ff;
      burst.write     = is_write_ff;

      case (in_kind)
         aps_pkg::KIND_START: begin
            if (phase_ff != aps_pkg::PH_IDLE || !drive_present_ff) begin
               burst.count = 4'd1;
               burst.first = aps_pkg::make_result(aps_pkg::OK_DONE, aps_pkg::TF_DATA,
                                                  16'h0000, aps_pkg::ST_REFUSED);
            end else if (in_count == 32'd0) begin
               burst.count   = 4'd1;
               burst.first   = done_ok;
               word_index_in = '0;
               poll_count_in = '0;
            end else begin
               is_write_in     = in_op_write;
               current_lba_in  = in_lba;
               sectors_left_in = in_count;
               word_index_in   = '0;
               poll_count_in   = '0;
               phase_in        = aps_pkg::PH_BSY;
            end
         end
         aps_pkg::KIND_STATUS: begin
            case (phase_ff)
               aps_pkg::PH_BSY: begin
                  if (!st_bsy) begin
                     burst.task_file = 1'b1;
                     burst.count     = lba48_ff ? aps_pkg::TF_BEATS_LBA48
                                                : aps_pkg::TF_BEATS_LBA28;
                     poll_count_in   = '0;
                     phase_in        = aps_pkg::PH_DRQ;
                  end else if (poll_expired) begin
                     burst.count   = 4'd1;
                     burst.first   = aps_pkg::make_result(aps_pkg::OK_DONE, aps_pkg::TF_DATA,
                                                          16'h0000, aps_pkg::ST_FAILED);
                     phase_in      = aps_pkg::PH_IDLE;
                     poll_count_in = '0;
                     word_index_in = '0;
                  end else begin
                     poll_count_in = poll_next[23:0];
                  end
               end
               aps_pkg::PH_DRQ: begin
                  if (st_err || (!st_drq && poll_expired)) begin
                     burst.count   = 4'd1;
                     burst.first   = aps_pkg::make_result(aps_pkg::OK_DONE, aps_pkg::TF_DATA,
                                                          16'h0000, aps_pkg::ST_FAILED);
                     phase_in      = aps_pkg::PH_IDLE;
                     poll_count_in = '0;
                     word_index_in = '0;
                  end else if (st_drq) begin
                     word_index_in = '0;
                     poll_count_in = '0;
                     phase_in      = aps_pkg::PH_DATA;
                  end else begin
                     poll_count_in = poll_next[23:0];
                  end
               end
               aps_pkg::PH_FLUSH: begin
                  // A flush timeout still completes the sector.
                  if (!st_bsy || poll_expired) begin
                     sectors_left_in = sectors_dec;
                     current_lba_in  = current_lba_ff + 48'd1;
                     word_index_in   = '0;
                     poll_count_in   = '0;
                     if (sectors_dec == 32'd0) begin
                        burst.count = 4'd1;
                        burst.first = done_ok;
                        phase_in    = aps_pkg::PH_IDLE;
                     end else begin
                        phase_in = aps_pkg::PH_BSY;
                     end
                  end else begin
                     poll_count_in = poll_next[23:0];
                  end
               end
               default: ;
            endcase
         end
         aps_pkg::KIND_DATA: begin
            if (phase_ff == aps_pkg::PH_DATA) begin
               burst.count   = 4'd1;
               burst.first   = aps_pkg::make_result(
                                  is_write_ff ? aps_pkg::OK_REG_WRITE : aps_pkg::OK_READ_WORD,
                                  aps_pkg::TF_DATA, in_word, aps_pkg::ST_SUCCESS);
               word_index_in = word_index_ff + WI_W'(1);
               if (last_word) begin
                  word_index_in = '0;
                  poll_count_in = '0;
                  if (is_write_ff) begin
                     // Last word of a write: follow with a cache flush.
                     burst.count  = 4'd2;
                     burst.second = aps_pkg::make_result(aps_pkg::OK_REG_WRITE,
                                                         aps_pkg::TF_COMMAND,
                                                         {8'h00, aps_pkg::CMD_FLUSH},
                                                         aps_pkg::ST_SUCCESS);
                     phase_in     = aps_pkg::PH_FLUSH;
                  end else begin
                     sectors_left_in = sectors_dec;
                     current_lba_in  = current_lba_ff + 48'd1;
                     if (sectors_dec == 32'd0) begin
                        burst.count  = 4'd2;
                        burst.second = done_ok;
                        phase_in     = aps_pkg::PH_IDLE;
                     end else begin
                        phase_in = aps_pkg::PH_BSY;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
   end

   // State registers, updated on each accepted input beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= aps_pkg::PH_IDLE;
         is_write_ff     <= 1'b0;
         current_lba_ff  <= '0;
         sectors_left_ff <= '0;
         word_index_ff   <= '0;
         poll_count_ff   <= '0;
      end else if (req_accept) begin
         phase_ff        <= phase_in;
         is_write_ff     <= is_write_in;
         current_lba_ff  <= current_lba_in;
         sectors_left_ff <= sectors_left_in;
         word_index_ff   <= word_index_in;
         poll_count_ff   <= poll_count_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         drive_present_ff <= 1'b0;
         drive_slave_ff   <= 1'b0;
         lba48_ff         <= 1'b0;
         poll_limit_ff    <= aps_pkg::POLL_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            aps_pkg::CSR_DRIVE_PRESENT: drive_present_ff <= csr_wdata[0];
            aps_pkg::CSR_DRIVE_SLAVE:   drive_slave_ff   <= csr_wdata[0];
            aps_pkg::CSR_LBA48:         lba48_ff         <= csr_wdata[0];
            aps_pkg::CSR_POLL_LIMIT:    poll_limit_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Result register and beat sequencing.
   aps_burst u_burst (
      .clock      (clock),
      .reset      (reset),
      .load       (burst_load),
      .burst      (burst),
      .ready      (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // A transfer in progress always has sectors left.
   `APS_ASSERT_IMP(a_active_has_sectors, phase_ff != aps_pkg::PH_IDLE, sectors_left_ff != 32'd0, "active transfer with no sectors left")

   // Input is taken only when the result register is empty or drains its final beat.
   `APS_ASSERT_IMP(a_ready_after_final, req_tready, !rsp_tvalid || (rsp_tready && rsp_tlast), "input taken while results still pending")

   // A start while busy leaves the running transfer alone.
   `APS_ASSERT_NEXT(a_busy_start_kept, req_accept && in_kind == aps_pkg::KIND_START && phase_ff != aps_pkg::PH_IDLE, $stable(sectors_left_ff) && $stable(current_lba_ff), "start while busy changed the transfer")

endmodule

`default_nettype wire

/* rtl/core/aps_burst.sv */
// Result register that plays out the beats caused by one accepted input beat.
`default_nettype none

module aps_burst (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire aps_pkg::burst_type burst,
   output logic                   ready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [23:0]            rsp_tdata,   // reg_addr[2:0], value[18:3], status[20:19]
   output logic [1:0]             rsp_tuser,   // out_kind[1:0]
   output logic                   rsp_tlast
);

   aps_pkg::burst_type  burst_ff;
   logic                valid_ff;
   logic [3:0]          beat_ff;
   logic                last_beat;
   aps_pkg::result_type cur;

   assign last_beat = (beat_ff == (burst_ff.count - 4'd1));
   assign ready     = !valid_ff || (rsp_tready && last_beat);

   // Beat counter and valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= 4'd0;
      end else if (load) begin
         valid_ff <= 1'b1;
         beat_ff  <= 4'd0;
      end else if (valid_ff && rsp_tready) begin
         if (last_beat) begin
            valid_ff <= 1'b0;
         end else begin
            beat_ff <= beat_ff + 4'd1;
         end
      end
   end

   // Descriptor of the run being played out.
   always_ff @(posedge clock) begin
      if (load) begin
         burst_ff <= burst;
      end
   end

   // Select the current beat.
   always_comb begin
      if (burst_ff.task_file) begin
         cur = aps_pkg::tf_beat(burst_ff, beat_ff);
      end else if (beat_ff == 4'd0) begin
         cur = burst_ff.first;
      end else begin
         cur = burst_ff.second;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {3'b000, cur.status, cur.value, cur.reg_addr};
   assign rsp_tuser  = cur.kind;
   assign rsp_tlast  = last_beat;

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the ATA PIO sector sequencer: directed and random beats.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import aps_pkg::*;

   localparam int          SECTOR_WORDS     = WORDS_PER_SECTOR_DEF;
   localparam int          CYCLE_LIMIT      = 600000;
   localparam int          SETTLE_CYCLES    = 24;
   localparam int          DEFAULT_IDLE_PCT = 6;
   localparam int          SESSION_STEPS    = 400;
   localparam logic [1:0]  KIND_UNUSED      = 2'd3;
   localparam logic [2:0]  ADDR_NONE        = 3'd0;
   localparam logic        OP_READ          = 1'b0;
   localparam logic        OP_WRITE         = 1'b1;
   localparam logic [47:0] LBA_TOP          = 48'hFFFF_FFFF_FFFF;
   localparam logic [7:0]  STAT_CLEAR       = 8'h00;
   localparam logic [7:0]  STAT_BSY         = 8'h01 << SR_BSY_BIT;
   localparam logic [7:0]  STAT_DRQ         = 8'h01 << SR_DRQ_BIT;
   localparam logic [7:0]  STAT_ERR         = 8'h01 << SR_ERR_BIT;

   // Fields of one request beat.
   typedef struct packed {
      logic        op_write;
      logic [47:0] lba;
      logic [31:0] count;
      logic [7:0]  status;
      logic [15:0] word;
   } req_fields_t;

   // Fields of one result beat.
   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  addr;
      logic [15:0] value;
      logic [1:0]  status;
      logic        last;
   } host_beat_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;   // op_write, lba, sector_count, status_byte, data_word, pad
   logic [1:0]   req_tuser = '0;   // kind
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [23:0]  rsp_tdata;        // reg_addr, value, status, pad
   logic [1:0]   rsp_tuser;        // out_kind
   logic         rsp_tlast;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [23:0]  csr_wdata = '0;

   int error_count = 0;
   int cycle_count = 0;
   int idle_pct = DEFAULT_IDLE_PCT;

   // Mirror of the sequencer's configuration and transfer state.
   logic        cfg_present = 1'b0;
   logic        cfg_slave = 1'b0;
   logic        cfg_lba48 = 1'b0;
   logic [23:0] cfg_poll_limit = POLL_LIMIT_RST;
   phase_type   seq_phase = PH_IDLE;
   logic        seq_write = 1'b0;
   logic [47:0] seq_lba = '0;
   logic [31:0] seq_left = '0;
   int          seq_word = 0;
   logic [23:0] seq_polls = '0;

   host_beat_t step_beats[$];
   host_beat_t host_side_beats[$];

   ata_pio_sector_sequencer_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Prediction of the result beats caused by one request beat.
   // ---------------------------------------------------------------------

   function automatic void add_beat(logic [1:0] kind, logic [2:0] addr, logic [15:0] value,
                                    logic [1:0] status);
      host_beat_t b;
      b.kind   = kind;
      b.addr   = addr;
      b.value  = value;
      b.status = status;
      b.last   = 1'b0;
      step_beats.push_back(b);
   endfunction

   function automatic void add_reg(logic [2:0] addr, logic [7:0] value);
      add_beat(OK_REG_WRITE, addr, {8'h00, value}, ST_SUCCESS);
   endfunction

   function automatic void end_transfer(logic [1:0] status);
      seq_phase = PH_IDLE;
      seq_polls = '0;
      seq_word  = 0;
      add_beat(OK_DONE, ADDR_NONE, 16'h0000, status);
   endfunction

   // Counts one unsuccessful status sample; returns 1 once the wait has run out.
   function automatic bit poll_run_out();
      logic [24:0] next;
      next = {1'b0, seq_polls} + 25'd1;
      if (next >= {1'b0, cfg_poll_limit}) return 1'b1;
      seq_polls = next[23:0];
      return 1'b0;
   endfunction

   function automatic void close_sector();
      seq_left  = seq_left - 32'd1;
      seq_lba   = seq_lba + 48'd1;
      seq_word  = 0;
      seq_polls = '0;
      if (seq_left == 32'd0) end_transfer(ST_SUCCESS);
      else seq_phase = PH_BSY;
   endfunction

   // Device select, LBA and count registers, then the command.
   function automatic void issue_task_file();
      logic [7:0] sel;
      logic [7:0] cmd;
      sel = cfg_slave ? DEV_SLAVE : 8'h00;
      if (cfg_lba48) begin
         cmd = seq_write ? CMD_WRITE_EXT : CMD_READ_EXT;
         add_reg(TF_DEVICE, DEV_LBA48 | sel);
         add_reg(TF_COUNT, 8'h00);
         add_reg(TF_LBA_LO, seq_lba[31:24]);
         add_reg(TF_LBA_MID, seq_lba[39:32]);
         add_reg(TF_LBA_HI, seq_lba[47:40]);
      end else begin
         cmd = seq_write ? CMD_WRITE : CMD_READ;
         add_reg(TF_DEVICE, DEV_LBA28 | sel | {4'h0, seq_lba[27:24]});
      end
      add_reg(TF_COUNT, 8'h01);
      add_reg(TF_LBA_LO, seq_lba[7:0]);
      add_reg(TF_LBA_MID, seq_lba[15:8]);
      add_reg(TF_LBA_HI, seq_lba[23:16]);
      add_reg(TF_COMMAND, cmd);
   endfunction

   function automatic void predict_sequencer(logic [1:0] kind, req_fields_t f);
      step_beats.delete();
      case (kind)
         KIND_START: begin
            if (seq_phase != PH_IDLE || !cfg_present) begin
               add_beat(OK_DONE, ADDR_NONE, 16'h0000, ST_REFUSED);
            end else if (f.count == 32'd0) begin
               end_transfer(ST_SUCCESS);
            end else begin
               seq_write = f.op_write;
               seq_lba   = f.lba;
               seq_left  = f.count;
               seq_word  = 0;
               seq_polls = '0;
               seq_phase = PH_BSY;
            end
         end
         KIND_STATUS: begin
            case (seq_phase)
               PH_BSY: begin
                  if (!f.status[SR_BSY_BIT]) begin
                     issue_task_file();
                     seq_polls = '0;
                     seq_phase = PH_DRQ;
                  end else if (poll_run_out()) begin
                     end_transfer(ST_FAILED);
                  end
               end
               PH_DRQ: begin
                  if (f.status[SR_ERR_BIT]) begin
                     end_transfer(ST_FAILED);
                  end else if (f.status[SR_DRQ_BIT]) begin
                     seq_word  = 0;
                     seq_polls = '0;
                     seq_phase = PH_DATA;
                  end else if (poll_run_out()) begin
                     end_transfer(ST_FAILED);
                  end
               end
               PH_FLUSH: begin
                  // A flush that never finishes still completes the sector.
                  if (!f.status[SR_BSY_BIT]) close_sector();
                  else if (poll_run_out()) close_sector();
               end
               default: ;
            endcase
         end
         KIND_DATA: begin
            if (seq_phase == PH_DATA) begin
               if (seq_write) add_beat(OK_REG_WRITE, TF_DATA, f.word, ST_SUCCESS);
               else add_beat(OK_READ_WORD, ADDR_NONE, f.word, ST_SUCCESS);
               seq_word++;
               if (seq_word >= SECTOR_WORDS) begin
                  if (seq_write) begin
                     add_reg(TF_COMMAND, CMD_FLUSH);
                     seq_word  = 0;
                     seq_polls = '0;
                     seq_phase = PH_FLUSH;
                  end else begin
                     close_sector();
                  end
               end
            end
         end
         default: ;
      endcase
      if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
      foreach (step_beats[i]) host_side_beats.push_back(step_beats[i]);
   endfunction

   // ---------------------------------------------------------------------
   // Result checking, receiver stalls and the cycle limit.
   // ---------------------------------------------------------------------

   function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (host_side_beats.size() == 0) begin
               $error("result beat with nothing expected: kind %0d value %0h",
                      rsp_tuser, rsp_tdata[18:3]);
               error_count++;
            end else begin
               compare_field("out_kind", host_side_beats[0].kind, rsp_tuser);
               compare_field("reg_addr", host_side_beats[0].addr, rsp_tdata[2:0]);
               compare_field("value", host_side_beats[0].value, rsp_tdata[18:3]);
               compare_field("status", host_side_beats[0].status, rsp_tdata[20:19]);
               compare_field("last", host_side_beats[0].last, rsp_tlast);
               void'(host_side_beats.pop_front());
            end
         end
         rsp_tready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Request side.
   // ---------------------------------------------------------------------

   function automatic req_fields_t random_fields();
      req_fields_t f;
      f.op_write  = $urandom_range(1);
      f.lba[47:32] = $urandom_range(16'hFFFF);
      f.lba[31:0] = $urandom();
      f.count     = $urandom();
      f.status    = $urandom_range(8'hFF);
      f.word      = $urandom_range(16'hFFFF);
      return f;
   endfunction

   // Sends one beat after a random gap and predicts its results once accepted.
   task automatic send_beat(logic [1:0] kind, req_fields_t f);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, f.word, f.status, f.count, f.lba, f.op_write};
      do @(posedge clock); while (!req_tready);
      predict_sequencer(kind, f);
   endtask

   task automatic send_start(logic op, logic [47:0] lba, logic [31:0] count);
      req_fields_t f;
      f          = random_fields();
      f.op_write = op;
      f.lba      = lba;
      f.count    = count;
      send_beat(KIND_START, f);
   endtask

   task automatic send_status(logic [7:0] status);
      req_fields_t f;
      f        = random_fields();
      f.status = status;
      send_beat(KIND_STATUS, f);
   endtask

   task automatic send_word(logic [15:0] word);
      req_fields_t f;
      f      = random_fields();
      f.word = word;
      send_beat(KIND_DATA, f);
   endtask

   // Data words with both extremes up front.
   task automatic send_words(int count);
      for (int i = 0; i < count; i++) begin
         if (i == 0) send_word(16'h0000);
         else if (i == 1) send_word(16'hFFFF);
         else send_word($urandom_range(16'hFFFF));
      end
   endtask

   // One sector with no errors; writes see a busy flush first.
   task automatic run_clean_sector();
      send_status(STAT_CLEAR);
      send_status(STAT_DRQ);
      send_words(SECTOR_WORDS);
      if (seq_write) begin
         send_status(STAT_BSY);
         send_status(STAT_CLEAR);
      end
   endtask

   // Drops valid and waits until every expected beat has arrived and the block has settled.
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (host_side_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all four registers while the block is idle.
   task automatic apply_settings(logic present, logic slave, logic lba48, logic [23:0] limit);
      wait_quiet();
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         case (i)
            0: begin csr_index <= CSR_DRIVE_PRESENT; csr_wdata <= {23'd0, present}; end
            1: begin csr_index <= CSR_DRIVE_SLAVE;   csr_wdata <= {23'd0, slave}; end
            2: begin csr_index <= CSR_LBA48;         csr_wdata <= {23'd0, lba48}; end
            default: begin csr_index <= CSR_POLL_LIMIT; csr_wdata <= limit; end
         endcase
         @(posedge clock);
      end
      csr_we         <= 1'b0;
      cfg_present    = present;
      cfg_slave      = slave;
      cfg_lba48      = lba48;
      cfg_poll_limit = limit;
   endtask

   // ---------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------

   // Reset configuration: no drive, so starts are refused and stray beats ignored.
   task automatic test_absent_drive();
      send_status(STAT_CLEAR);
      send_word(16'hFFFF);
      send_beat(KIND_UNUSED, random_fields());
      send_start(OP_READ, 48'd0, 32'd1);
   endtask

   task automatic test_zero_sectors();
      apply_settings(1'b1, 1'b0, 1'b0, POLL_LIMIT_RST);
      send_start(OP_WRITE, random_fields().lba, 32'd0);
   endtask

   // LBA28 read of the top LBA on the slave, with a refused start and stray status mid-data.
   task automatic test_read_lba28();
      apply_settings(1'b1, 1'b1, 1'b0, POLL_LIMIT_RST);
      send_start(OP_READ, LBA_TOP, 32'd1);
      send_status(STAT_BSY);
      send_status(~STAT_BSY);
      send_status(STAT_CLEAR);
      send_status(STAT_DRQ);
      send_word(16'h0000);
      send_start(OP_WRITE, 48'd5, 32'd3);
      send_status(8'hFF);
      send_word(16'hFFFF);
      send_words(SECTOR_WORDS - 2);
   endtask

   // LBA48 write of two sectors across the top of the address space.
   task automatic test_write_lba48_wrap();
      apply_settings(1'b1, 1'b0, 1'b1, POLL_LIMIT_RST);
      send_start(OP_WRITE, LBA_TOP, 32'd2);
      repeat (2) run_clean_sector();
   endtask

   // Busy, DRQ and flush timeouts, device error, and a zero poll limit.
   task automatic test_poll_timeouts();
      apply_settings(1'b1, 1'b1, 1'b1, 24'd0);
      send_start(OP_READ, random_fields().lba, 32'd3);
      send_status(STAT_BSY);
      apply_settings(1'b1, 1'b0, 1'b1, 24'd2);
      send_start(OP_READ, random_fields().lba, 32'd1);
      send_status(STAT_BSY);
      send_status(STAT_BSY);
      send_start(OP_WRITE, random_fields().lba, 32'd1);
      send_status(STAT_CLEAR);
      send_status(STAT_CLEAR);
      send_status(STAT_CLEAR);
      send_start(OP_READ, random_fields().lba, 32'd1);
      send_status(STAT_CLEAR);
      send_status(STAT_ERR | STAT_DRQ);
      apply_settings(1'b1, 1'b0, 1'b0, 24'd1);
      send_start(OP_WRITE, random_fields().lba, 32'd1);
      run_clean_sector();
      send_start(OP_READ, 48'd0, 32'hFFFF_FFFF);
      send_status(STAT_CLEAR);
      send_status(STAT_ERR);
   endtask

   // Random transfers under one setting: mostly well-formed, some noise and errors.
   task automatic run_random_group(logic present, logic slave, logic lba48, logic [23:0] limit,
                                   int quiet_pct, int sessions);
      req_fields_t f;
      logic [7:0]  st;
      int          steps;
      int          pick;
      apply_settings(present, slave, lba48, limit);
      idle_pct = quiet_pct;
      repeat (sessions) begin
         // Stray beats while nothing runs.
         repeat ($urandom_range(3)) begin
            pick = $urandom_range(2);
            send_beat(pick == 0 ? KIND_STATUS : (pick == 1 ? KIND_DATA : KIND_UNUSED),
                      random_fields());
         end

         // Start with mostly short counts, a few zero or huge.
         f    = random_fields();
         pick = $urandom_range(99);
         if (pick < 8) f.count = 32'd0;
         else if (pick < 70) f.count = 32'd1;
         else if (pick < 88) f.count = 32'd2;
         if ($urandom_range(99) < 10) f.lba = LBA_TOP;
         send_beat(KIND_START, f);

         // Status and data fitting the current phase.
         steps = 0;
         while (seq_phase != PH_IDLE && steps < SESSION_STEPS) begin
            steps++;
            f    = random_fields();
            st   = f.status;
            pick = $urandom_range(99);
            if (pick < 6) begin
               send_beat($urandom_range(3), f);
            end else begin
               case (seq_phase)
                  PH_BSY: begin
                     st[SR_BSY_BIT] = (pick < 35);
                     send_status(st);
                  end
                  PH_DRQ: begin
                     st[SR_ERR_BIT] = (pick < 14);
                     st[SR_DRQ_BIT] = (pick >= 40);
                     send_status(st);
                  end
                  PH_FLUSH: begin
                     st[SR_BSY_BIT] = (pick < 40);
                     send_status(st);
                  end
                  default: send_word(f.word);
               endcase
            end
         end

         // Bring any long transfer to an end, failing it at the next DRQ wait.
         while (seq_phase != PH_IDLE) begin
            st = $urandom_range(8'hFF);
            case (seq_phase)
               PH_DATA: send_word($urandom_range(16'hFFFF));
               PH_DRQ: begin
                  st[SR_ERR_BIT] = 1'b1;
                  send_status(st);
               end
               default: begin
                  st[SR_BSY_BIT] = 1'b0;
                  send_status(st);
               end
            endcase
         end
      end
      idle_pct = DEFAULT_IDLE_PCT;
   endtask

   task automatic test_random_traffic();
      run_random_group(1'b1, $urandom_range(1), $urandom_range(1), 24'hFF_FFFF,
                       DEFAULT_IDLE_PCT, 3);
      run_random_group(1'b1, 1'b1, 1'b1, $urandom_range(1, 4), 0, 3);
      run_random_group(1'b0, $urandom_range(1), 1'b0, $urandom_range(1, 8),
                       DEFAULT_IDLE_PCT, 2);
      run_random_group(1'b1, 1'b0, 1'b0, $urandom_range(5, 40), DEFAULT_IDLE_PCT, 3);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_absent_drive();
      test_zero_sectors();
      test_read_lba28();
      test_write_lba48_wrap();
      test_poll_timeouts();
      test_random_traffic();
      wait_quiet();
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+rtl/core
rtl/core/aps_pkg.sv
rtl/core/aps_burst.sv
rtl/core/ata_pio_sector_sequencer_unit.sv
verif/tb.sv
